// ===== sv/sgrc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgrc_pkg
// Shared types and constants for the servo gate ramp controller.
// ----------------------------------------------------------------------------
package sgrc_pkg;

  localparam int PULSE_W = 15;
  localparam int STEP_W  = 10;
  localparam int HOLD_W  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [PULSE_W-1:0] PULSE_MAX          = 15'd20000;
  localparam logic [PULSE_W-1:0] CLOSED_PULSE_RESET = 15'd1500;
  localparam logic [PULSE_W-1:0] OPEN_PULSE_RESET   = 15'd850;
  localparam logic [STEP_W-1:0]  RAMP_STEP_RESET    = 10'd13;
  localparam logic [HOLD_W-1:0]  HOLD_FRAMES_RESET  = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOSED_PULSE = 8'd0,
    REG_OPEN_PULSE   = 8'd1,
    REG_RAMP_STEP    = 8'd2,
    REG_HOLD_FRAMES  = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_OPENING = 2'd1,
    PHASE_HOLD    = 2'd2,
    PHASE_CLOSING = 2'd3
  } phase_t;

  typedef struct packed {
    logic [PULSE_W-1:0] closed_pulse;
    logic [PULSE_W-1:0] open_pulse;
    logic [STEP_W-1:0]  ramp_step;
    logic [HOLD_W-1:0]  hold_frames;
  } gate_cfg_t;

  typedef struct packed {
    phase_t             mode;
    logic [PULSE_W-1:0] pulse;
    logic [HOLD_W-1:0]  hold;
  } gate_state_t;

endpackage

// ===== sv/servo_gate_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// servo_gate_ramp_controller
// Per-frame servo pulse width with open ramp, hold and close ramp.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_trigger
//   out      output     out_valid/out_stall out_frame_pulse, out_gate_phase
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// One frame per cycle while out_stall is low; a frame's result passes through the
// input register, then the step logic into the result register.
// Reset clears the gate to idle, pulse 1500, hold 0 and loads register defaults.
// A stalled result holds; the input register keeps taking one more word.
// ----------------------------------------------------------------------------
module servo_gate_ramp_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_trigger,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sgrc_pkg::PULSE_W-1:0]     out_frame_pulse,
  output logic [1:0]                       out_gate_phase,
  input  logic                             cfg_we,
  input  logic [sgrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgrc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sgrc_pkg::*;

  gate_cfg_t   cfg_r;
  gate_state_t state_r;
  gate_state_t state_nxt;
  logic        a_valid_r;
  logic        a_trig_r;
  logic        b_valid_r;
  logic [PULSE_W-1:0] b_pulse_r;
  phase_t      b_phase_r;
  logic [PULSE_W-1:0] pulse_nxt;
  logic        b_adv;
  logic        a_load;
  logic [PULSE_W-1:0] cfg_pulse_sat;

  assign b_adv    = !b_valid_r || !out_stall;
  assign in_stall = a_valid_r && !b_adv;
  assign a_load   = in_valid && !in_stall;

  assign cfg_pulse_sat = (cfg_wdata[PULSE_W-1:0] > PULSE_MAX) ? PULSE_MAX
                                                              : cfg_wdata[PULSE_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.closed_pulse <= CLOSED_PULSE_RESET;
      cfg_r.open_pulse   <= OPEN_PULSE_RESET;
      cfg_r.ramp_step    <= RAMP_STEP_RESET;
      cfg_r.hold_frames  <= HOLD_FRAMES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOSED_PULSE: cfg_r.closed_pulse <= cfg_pulse_sat;
        REG_OPEN_PULSE:   cfg_r.open_pulse   <= cfg_pulse_sat;
        REG_RAMP_STEP:    cfg_r.ramp_step    <= cfg_wdata[STEP_W-1:0];
        REG_HOLD_FRAMES:  cfg_r.hold_frames  <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  sgrc_step u_step (
    .trigger     (a_trig_r),
    .state_cur   (state_r),
    .cfg         (cfg_r),
    .state_nxt   (state_nxt),
    .frame_pulse (pulse_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_trig_r <= in_trigger;
    end
  end

  // gate state advances when a frame moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode  <= PHASE_IDLE;
      state_r.pulse <= CLOSED_PULSE_RESET;
      state_r.hold  <= '0;
      b_valid_r     <= 1'b0;
    end else if (b_adv) begin
      b_valid_r <= a_valid_r;
      if (a_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid_r) begin
      b_pulse_r <= pulse_nxt;
      b_phase_r <= state_nxt.mode;
    end
  end

  assign out_valid       = b_valid_r;
  assign out_frame_pulse = b_pulse_r;
  assign out_gate_phase  = b_phase_r;

  // holding frames always report the open width
  a_hold_width: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_phase_r == PHASE_HOLD) |-> (b_pulse_r == cfg_r.open_pulse))
    else $error("hold frame width differs from open width");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && b_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_pulse_r <= PULSE_MAX))
    else $error("frame width out of range");

  a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
    (b_adv && a_valid_r && state_nxt.mode == PHASE_IDLE
     && state_r.mode == PHASE_IDLE) |-> (pulse_nxt == '0))
    else $error("idle frame produced a pulse");

endmodule

// ===== sv/sgrc_step.sv =====
// ----------------------------------------------------------------------------
// sgrc_step
// One frame tick: applies the trigger, then ramps, holds or closes the gate.
// ----------------------------------------------------------------------------
module sgrc_step (
  input  logic                       trigger,
  input  sgrc_pkg::gate_state_t      state_cur,
  input  sgrc_pkg::gate_cfg_t        cfg,
  output sgrc_pkg::gate_state_t      state_nxt,
  output logic [sgrc_pkg::PULSE_W-1:0] frame_pulse
);
  import sgrc_pkg::*;

  // one step toward target, landing exactly on it when close enough
  function automatic logic [PULSE_W-1:0] ramp(input logic [PULSE_W-1:0] v,
                                              input logic [PULSE_W-1:0] t,
                                              input logic [STEP_W-1:0]  s);
    logic [PULSE_W-1:0] diff;
    logic [PULSE_W-1:0] step;
    logic [PULSE_W-1:0] res;
    begin
      step = {{(PULSE_W-STEP_W){1'b0}}, s};
      if (v < t) begin
        diff = t - v;
        res  = (diff <= step) ? t : v + step;
      end else begin
        diff = v - t;
        res  = (diff <= step) ? t : v - step;
      end
      ramp = res;
    end
  endfunction

  gate_state_t        trig_st;
  logic [STEP_W-1:0]  step_eff;

  assign step_eff = (cfg.ramp_step == '0) ? STEP_W'(1) : cfg.ramp_step;

  always_comb begin
    trig_st = state_cur;
    if (trigger) begin
      unique case (state_cur.mode)
        PHASE_IDLE: begin
          trig_st.pulse = cfg.closed_pulse;
          trig_st.hold  = '0;
          trig_st.mode  = PHASE_OPENING;
        end
        PHASE_HOLD:    trig_st.hold = cfg.hold_frames;
        PHASE_CLOSING: trig_st.mode = PHASE_OPENING;
        PHASE_OPENING: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = trig_st;
    frame_pulse = '0;
    unique case (trig_st.mode)
      PHASE_OPENING: begin
        frame_pulse = trig_st.pulse;
        if (trig_st.pulse == cfg.open_pulse) begin
          state_nxt.mode = PHASE_HOLD;
          state_nxt.hold = cfg.hold_frames;
        end else begin
          state_nxt.pulse = ramp(trig_st.pulse, cfg.open_pulse, step_eff);
        end
      end
      PHASE_HOLD: begin
        frame_pulse = cfg.open_pulse;
        if (trig_st.hold != '0) begin
          state_nxt.hold = trig_st.hold - HOLD_W'(1);
        end else begin
          state_nxt.pulse = cfg.open_pulse;
          state_nxt.mode  = PHASE_CLOSING;
        end
      end
      PHASE_CLOSING: begin
        frame_pulse = trig_st.pulse;
        if (trig_st.pulse == cfg.closed_pulse) begin
          state_nxt.mode = PHASE_IDLE;
        end else begin
          state_nxt.pulse = ramp(trig_st.pulse, cfg.closed_pulse, step_eff);
        end
      end
      default: begin
        frame_pulse    = '0;
        state_nxt.mode = PHASE_IDLE;
      end
    endcase
  end

endmodule
